### rtl/pwf_pkg.sv
// ----------------------------------------------------------------------------
// pwf_pkg
// widths, register indexes and fixed-point constants for the pid core
// ----------------------------------------------------------------------------
package pwf_pkg;

	// sample and gain formats
	localparam int SMP_W  = 16;   // Q8.8 samples and drive
	localparam int GAIN_W = 24;   // Q12.12 gains
	localparam int ERR_W  = 17;   // Q9.8 error
	localparam int DIFF_W = 18;   // Q10.8 derivative
	localparam int SUM_W  = 32;   // Q24.8 error sum
	localparam int ACC_W  = 58;   // exact sum of the four products
	localparam int FRAC_DROP = 12; // 20 fraction bits down to 8
	localparam int Q_W    = ACC_W - FRAC_DROP;

	// configuration port
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_KP        = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KI_DT     = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KD_DIV_DT = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FF_GAIN   = 4'd3;

	// rounding half up before the fraction drop
	localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(2048);

	// drive limits
	localparam logic signed [Q_W-1:0] DRIVE_MAX = Q_W'(32767);
	localparam logic signed [Q_W-1:0] DRIVE_MIN = -Q_W'(32768);

	// error sum limits
	localparam logic signed [SUM_W-1:0] ESUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] ESUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

endpackage

### rtl/pid_with_feedforward_core.sv
// ----------------------------------------------------------------------------
// pid_with_feedforward_core
// fixed-point pid controller with setpoint feedforward, when not stalled one sample per cycle
// ----------------------------------------------------------------------------
//
//  channel   signals                                   direction  beat
//  -------   ---------------------------------------   ---------  ----------------
//  in        in_valid, in_stall, target, measured      sink       one sample
//  out       out_valid, out_stall, drive, clipped      source     one control value
//  cfg       cfg_valid, cfg_ready, cfg_index, cfg_data sink       one gain write
//
//  one sample per clock sustained while out_stall is low; a sample is captured in
//  the input register and then moves on into the result register
//  the error sum, previous error and first-sample flag update when a sample
//  leaves the input register, so back-to-back samples see each other's state
//  arst_n clears valids, the gains, the error sum and previous error, and sets
//  the first-sample flag; payload registers are not reset
//  a stalled result holds; the input register still takes one more beat
//  cfg_ready is always high, gain writes land in the gain registers at the next clock edge
//
module pid_with_feedforward_core
	import pwf_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [SMP_W-1:0]     target,
	input  logic signed [SMP_W-1:0]     measured,

	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [SMP_W-1:0]     drive,
	output logic                        clipped,

	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [GAIN_W-1:0]           cfg_data
);

	// gain registers
	logic signed [GAIN_W-1:0] kp_q, ki_dt_q, kd_div_dt_q, ff_gain_q;

	// controller state
	logic signed [SUM_W-1:0]  err_sum_q;
	logic signed [ERR_W-1:0]  last_err_q;
	logic                     first_q;

	// input register
	logic                     valid_s1;
	logic signed [SMP_W-1:0]  tgt_s1, meas_s1;

	// result register
	logic                     out_valid_q;
	logic signed [SMP_W-1:0]  drive_q;
	logic                     clip_q;

	logic advance;      // input register moves into the result register
	logic in_take;

	// datapath
	logic signed [ERR_W-1:0]    err;
	logic signed [SUM_W:0]      sum_wide;
	logic signed [SUM_W-1:0]    sum_sat;
	logic                       sum_clip;
	logic signed [DIFF_W-1:0]   diff;
	logic signed [GAIN_W+ERR_W-1:0]  p_kp;
	logic signed [GAIN_W+SUM_W-1:0]  p_ki;
	logic signed [GAIN_W+DIFF_W-1:0] p_kd;
	logic signed [GAIN_W+SMP_W-1:0]  p_ff;
	logic signed [ACC_W-1:0]    acc;
	logic signed [ACC_W-1:0]    acc_rnd;
	logic signed [Q_W-1:0]      q_full;
	logic signed [SMP_W-1:0]    drive_nx;
	logic                       drive_clip;

	// handshakes: the result register frees up when empty or taken
	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// error and saturating error sum
	assign err      = ERR_W'(tgt_s1) - ERR_W'(meas_s1);
	assign sum_wide = (SUM_W+1)'(err_sum_q) + (SUM_W+1)'(err);

	always_comb begin
		sum_sat  = sum_wide[SUM_W-1:0];
		sum_clip = 1'b0;
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
			sum_clip = 1'b1;
			sum_sat  = sum_wide[SUM_W] ? ESUM_MIN : ESUM_MAX;
		end
	end

	// derivative is held at zero on the first sample after reset
	assign diff = first_q ? '0 : (DIFF_W'(err) - DIFF_W'(last_err_q));

	// four products, each exact with 20 fraction bits
	assign p_kp = kp_q * err;
	assign p_ki = ki_dt_q * sum_sat;
	assign p_kd = kd_div_dt_q * diff;
	assign p_ff = ff_gain_q * tgt_s1;

	assign acc = ACC_W'(p_kp) + ACC_W'(p_ki) + ACC_W'(p_kd) + ACC_W'(p_ff);

	// round half up, drop 12 fraction bits
	assign acc_rnd = acc + RND_HALF;
	assign q_full  = Q_W'(acc_rnd >>> FRAC_DROP);

	always_comb begin
		drive_nx   = q_full[SMP_W-1:0];
		drive_clip = 1'b0;
		if (q_full > DRIVE_MAX) begin
			drive_nx   = DRIVE_MAX[SMP_W-1:0];
			drive_clip = 1'b1;
		end else if (q_full < DRIVE_MIN) begin
			drive_nx   = DRIVE_MIN[SMP_W-1:0];
			drive_clip = 1'b1;
		end
	end

	// gain writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q        <= '0;
			ki_dt_q     <= '0;
			kd_div_dt_q <= '0;
			ff_gain_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_KP:        kp_q        <= cfg_data;
				REG_KI_DT:     ki_dt_q     <= cfg_data;
				REG_KD_DIV_DT: kd_div_dt_q <= cfg_data;
				REG_FF_GAIN:   ff_gain_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance || in_take) begin
			valid_s1 <= in_take;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			tgt_s1  <= target;
			meas_s1 <= measured;
		end
	end

	// controller state moves with each sample that leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_sum_q  <= '0;
			last_err_q <= '0;
			first_q    <= 1'b1;
		end else if (valid_s1 && advance) begin
			err_sum_q  <= sum_sat;
			last_err_q <= err;
			first_q    <= 1'b0;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			drive_q <= drive_nx;
			clip_q  <= sum_clip || drive_clip;
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign clipped   = clip_q;

	// a sample in the input register always lands in the result register
	a_s1_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance |=> out_valid_q)
		else $error("sample lost between input and result register");

	// an empty result register never holds off the input
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> !in_stall)
		else $error("input stalled with empty result register");

	// the derivative is live after the first processed sample
	a_first_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance |=> !first_q)
		else $error("first-sample flag still set after a sample");

	// the error sum only changes when a sample is processed
	a_sum_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && advance) |=> $stable(err_sum_q))
		else $error("error sum changed without a sample");

endmodule
